// File: design/esa_pkg.sv
// shared types, constants and gain table for the encoder step acceleration unit
package esa_pkg;

  localparam int COUNT_W  = 16;
  localparam int DELTA_W  = 7;
  localparam int TIME_W   = 32;
  localparam int CHANGE_W = 16;
  localparam int ACCUM_W  = 8;
  localparam int GAIN_W   = 10;
  localparam int ROW_W    = 4;
  localparam int COL_W    = 4;
  localparam int THR_W    = 5;
  localparam int ROWS     = 9;
  localparam int COLS     = 10;
  localparam int IDX_W    = 2;
  localparam int TDATA_W  = 40;

  localparam logic [COUNT_W-1:0] ROW_MASK     = 16'h3FFF;
  localparam logic [COUNT_W-1:0] DIVIDE_LIMIT = 16'd63;
  localparam int                 MS_PER_COL   = 10;
  localparam int                 ROW_BASE_BIT = 5;

  localparam logic [IDX_W-1:0] REG_VALUE_COUNT  = 2'd0;
  localparam logic [IDX_W-1:0] REG_ENCODER_MODE = 2'd1;

  localparam logic OP_MOVE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic [COUNT_W-1:0] value_count;
    logic               encoder_mode;
  } cfg_t;

  localparam logic [GAIN_W-1:0] GAIN [ROWS][COLS] = '{
    '{10'd1, 10'd1, 10'd1,  10'd1,  10'd1,  10'd1,  10'd1,   10'd1,   10'd1,   10'd2},
    '{10'd1, 10'd1, 10'd1,  10'd1,  10'd1,  10'd1,  10'd2,   10'd2,   10'd2,   10'd3},
    '{10'd1, 10'd1, 10'd1,  10'd2,  10'd2,  10'd3,  10'd4,   10'd6,   10'd8,   10'd10},
    '{10'd1, 10'd2, 10'd3,  10'd4,  10'd5,  10'd6,  10'd7,   10'd9,   10'd11,  10'd14},
    '{10'd1, 10'd2, 10'd3,  10'd4,  10'd6,  10'd8,  10'd10,  10'd13,  10'd18,  10'd25},
    '{10'd1, 10'd2, 10'd4,  10'd8,  10'd10, 10'd13, 10'd20,  10'd32,  10'd48,  10'd64},
    '{10'd1, 10'd2, 10'd4,  10'd8,  10'd16, 10'd24, 10'd32,  10'd48,  10'd64,  10'd128},
    '{10'd1, 10'd4, 10'd8,  10'd16, 10'd32, 10'd48, 10'd64,  10'd96,  10'd128, 10'd256},
    '{10'd1, 10'd8, 10'd16, 10'd32, 10'd64, 10'd96, 10'd128, 10'd192, 10'd256, 10'd512}
  };

endpackage

// File: design/esa_steps.sv
// step division: accumulates deltas and emits one step per threshold crossing
module esa_steps (
  input  esa_pkg::cfg_t                        cfg,
  input  logic signed [esa_pkg::ACCUM_W-1:0]   step_accum,
  input  logic signed [esa_pkg::DELTA_W-1:0]   delta,
  output logic signed [esa_pkg::ACCUM_W-1:0]   accum_next,
  output logic signed [esa_pkg::CHANGE_W-1:0]  change
);

  logic signed [esa_pkg::ACCUM_W-1:0] acc;
  logic [esa_pkg::ACCUM_W-1:0]        mag;
  logic [esa_pkg::THR_W-1:0]          thr;
  logic                               hit;

  always_comb begin
    acc = step_accum + esa_pkg::ACCUM_W'(delta);
    mag = acc[esa_pkg::ACCUM_W-1] ? esa_pkg::ACCUM_W'(-acc) : esa_pkg::ACCUM_W'(acc);
    // threshold follows the bit length of value_count
    if (cfg.encoder_mode) begin
      if (cfg.value_count >= 16'd128) begin
        thr = 5'd2;
      end else if (cfg.value_count >= 16'd64) begin
        thr = 5'd4;
      end else if (cfg.value_count >= 16'd32) begin
        thr = 5'd8;
      end else begin
        thr = 5'd16;
      end
    end else begin
      if (cfg.value_count >= 16'd16) begin
        thr = 5'd1;
      end else if (cfg.value_count >= 16'd8) begin
        thr = 5'd2;
      end else if (cfg.value_count >= 16'd4) begin
        thr = 5'd4;
      end else if (cfg.value_count >= 16'd2) begin
        thr = 5'd8;
      end else begin
        thr = 5'd16;
      end
    end
    hit = mag >= esa_pkg::ACCUM_W'(thr);
    if (hit) begin
      accum_next = '0;
      change     = acc[esa_pkg::ACCUM_W-1] ? -16'sd1 : 16'sd1;
    end else begin
      accum_next = acc;
      change     = '0;
    end
  end

endmodule

// File: design/esa_gain.sv
// acceleration: row from value_count size, column from move interval, gain times delta
module esa_gain (
  input  logic [esa_pkg::COUNT_W-1:0]          value_count,
  input  logic [esa_pkg::TIME_W-1:0]           time_ms,
  input  logic [esa_pkg::TIME_W-1:0]           last_move_time,
  input  logic signed [esa_pkg::DELTA_W-1:0]   delta,
  output logic signed [esa_pkg::CHANGE_W-1:0]  change
);

  logic [esa_pkg::COUNT_W-1:0]  masked;
  logic [esa_pkg::TIME_W-1:0]   interval;
  logic [esa_pkg::ROW_W-1:0]    row;
  logic [esa_pkg::COL_W-1:0]    col;
  logic [esa_pkg::GAIN_W-1:0]   gain;
  logic signed [esa_pkg::GAIN_W+esa_pkg::DELTA_W:0] product;

  always_comb begin
    masked = value_count & esa_pkg::ROW_MASK;
    row = '0;
    for (int i = esa_pkg::ROW_BASE_BIT + 1; i < 14; i++) begin
      if (masked[i]) begin
        row = esa_pkg::ROW_W'(i - esa_pkg::ROW_BASE_BIT);
      end
    end

    interval = time_ms - last_move_time;
    // one column per 10 ms, fastest column below 20 ms
    if (|interval[esa_pkg::TIME_W-1:7] || interval[6:0] >= 7'(esa_pkg::COLS * esa_pkg::MS_PER_COL))
    begin
      col = '0;
    end else begin
      col = esa_pkg::COL_W'(esa_pkg::COLS - 1);
      for (int k = 2; k < esa_pkg::COLS; k++) begin
        if (interval[6:0] >= 7'(k * esa_pkg::MS_PER_COL)) begin
          col = esa_pkg::COL_W'(esa_pkg::COLS - k);
        end
      end
    end

    gain    = esa_pkg::GAIN[row][col];
    product = $signed({1'b0, gain}) * delta;
    change  = product[esa_pkg::CHANGE_W-1:0];
  end

endmodule

// File: design/encoder_step_acceleration_unit.sv
// top level: input register, step and gain paths, state and result register
//
// usage:
//   s_axis carries one move or clear word per handshake; tuser is the op
//   (0 move, 1 clear), tdata holds delta in bits 6:0 and time_ms in 38:7.
//   m_axis returns one word per input word: scaled_change in tdata 15:0.
//   cfg writes value_count (index 0) and encoder_mode (index 1); cfg_ready
//   is always high and writes belong to idle periods only.
// timing:
//   a word accepted into the input register is processed from there and,
//   unless m_axis stalls, written into the result register that drives m_axis.
//   throughput is one word per cycle while m_axis_tready is high, set by the
//   state update of the step counter and last move time in the processing stage.
// reset:
//   rst clears both stages, the step counter, the last move time and the
//   configuration registers.
// stall:
//   while m_axis_tready is low a valid result word holds in place; the input
//   register still takes one more word, then s_axis_tready drops.
module encoder_step_acceleration_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [esa_pkg::TDATA_W-1:0]       s_axis_tdata,   // delta, time_ms, zero pad
  input  logic                              s_axis_tuser,   // op
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [esa_pkg::CHANGE_W-1:0]      m_axis_tdata,   // scaled_change
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [esa_pkg::IDX_W-1:0]         cfg_index,
  input  logic [esa_pkg::COUNT_W-1:0]       cfg_data
);

  esa_pkg::cfg_t cfg;

  logic                                  in_valid;
  logic                                  in_op;
  logic signed [esa_pkg::DELTA_W-1:0]    in_delta;
  logic [esa_pkg::TIME_W-1:0]            in_time;

  logic signed [esa_pkg::ACCUM_W-1:0]    step_accum;
  logic signed [esa_pkg::ACCUM_W-1:0]    step_accum_next;
  logic [esa_pkg::TIME_W-1:0]            last_move_time;
  logic [esa_pkg::TIME_W-1:0]            last_move_time_next;

  logic                                  out_valid;
  logic signed [esa_pkg::CHANGE_W-1:0]   result;
  logic signed [esa_pkg::CHANGE_W-1:0]   result_next;

  logic signed [esa_pkg::ACCUM_W-1:0]    div_accum;
  logic signed [esa_pkg::CHANGE_W-1:0]   div_change;
  logic signed [esa_pkg::CHANGE_W-1:0]   acc_change;
  logic                                  advance;
  logic                                  divide_mode;

  assign cfg_ready     = 1'b1;
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = result;

  esa_steps u_steps (
    .cfg        (cfg),
    .step_accum (step_accum),
    .delta      (in_delta),
    .accum_next (div_accum),
    .change     (div_change)
  );

  esa_gain u_gain (
    .value_count    (cfg.value_count),
    .time_ms        (in_time),
    .last_move_time (last_move_time),
    .delta          (in_delta),
    .change         (acc_change)
  );

  always_comb begin
    divide_mode         = (cfg.value_count < esa_pkg::DIVIDE_LIMIT) || cfg.encoder_mode;
    step_accum_next     = step_accum;
    last_move_time_next = last_move_time;
    if (in_op == esa_pkg::OP_CLEAR) begin
      step_accum_next = '0;
      result_next     = '0;
    end else if (divide_mode) begin
      step_accum_next = div_accum;
      result_next     = div_change;
    end else begin
      last_move_time_next = in_time;
      result_next         = acc_change;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid         <= 1'b0;
      out_valid        <= 1'b0;
      step_accum       <= '0;
      last_move_time   <= '0;
      cfg.value_count  <= '0;
      cfg.encoder_mode <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid      <= 1'b1;
        step_accum     <= step_accum_next;
        last_move_time <= last_move_time_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          esa_pkg::REG_VALUE_COUNT:  cfg.value_count  <= cfg_data;
          esa_pkg::REG_ENCODER_MODE: cfg.encoder_mode <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op    <= s_axis_tuser;
      in_delta <= s_axis_tdata[esa_pkg::DELTA_W-1:0];
      in_time  <= s_axis_tdata[esa_pkg::DELTA_W +: esa_pkg::TIME_W];
    end
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

// File: tb/sv/esa_checker.sv
// checker: shadow of the step divider and gain path, compares every result word
`timescale 1ns / 1ps
module esa_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [esa_pkg::TDATA_W-1:0]   s_axis_tdata,   // delta, time_ms, zero pad
  input  logic                          s_axis_tuser,   // op
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [esa_pkg::CHANGE_W-1:0]  m_axis_tdata,   // scaled_change
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [esa_pkg::IDX_W-1:0]     cfg_index,
  input  logic [esa_pkg::COUNT_W-1:0]   cfg_data,
  output int                            errors,
  output int                            pending
);

  localparam int ACCEL_GAIN [9][10] = '{
    '{1, 1, 1,  1,  1,  1,  1,   1,   1,   2},
    '{1, 1, 1,  1,  1,  1,  2,   2,   2,   3},
    '{1, 1, 1,  2,  2,  3,  4,   6,   8,   10},
    '{1, 2, 3,  4,  5,  6,  7,   9,   11,  14},
    '{1, 2, 3,  4,  6,  8,  10,  13,  18,  25},
    '{1, 2, 4,  8,  10, 13, 20,  32,  48,  64},
    '{1, 2, 4,  8,  16, 24, 32,  48,  64,  128},
    '{1, 4, 8,  16, 32, 48, 64,  96,  128, 256},
    '{1, 8, 16, 32, 64, 96, 128, 192, 256, 512}
  };

  logic [esa_pkg::COUNT_W-1:0]         count_reg;
  logic                                enc_mode_reg;
  logic signed [esa_pkg::ACCUM_W-1:0]  step_count;
  logic [esa_pkg::TIME_W-1:0]          last_accel_ms;
  logic signed [esa_pkg::CHANGE_W-1:0] change_q [$];

  function automatic int lead_zero_count(input logic [31:0] w);
    int n;
    n = 0;
    while (n < 32 && !w[31-n]) n++;
    return n;
  endfunction

  function automatic logic signed [esa_pkg::CHANGE_W-1:0] shape_move(
      input logic op,
      input logic signed [esa_pkg::DELTA_W-1:0] delta,
      input logic [esa_pkg::TIME_W-1:0] now_ms);
    int lz;
    int shift;
    int limit;
    int acc;
    int row;
    int tens;
    int col;
    logic [esa_pkg::TIME_W-1:0] gap_ms;
    if (op == esa_pkg::OP_CLEAR) begin
      step_count = '0;
      return '0;
    end
    if (count_reg < esa_pkg::DIVIDE_LIMIT || enc_mode_reg) begin
      lz = lead_zero_count(32'(count_reg));
      step_count = step_count + delta;
      if (enc_mode_reg) begin
        shift = (lz > 24) ? lz - 24 : 0;
        limit = (shift >= 3) ? 16 : 2 << shift;
      end else begin
        shift = (lz > 27) ? lz - 27 : 0;
        limit = (shift >= 4) ? 16 : 1 << shift;
      end
      acc = step_count;
      if ((acc < 0 ? -acc : acc) >= limit) begin
        step_count = '0;
        return (acc > 0) ? 16'sd1 : -16'sd1;
      end
      return '0;
    end
    // fine parameter: gain from time since the last accelerated move
    gap_ms = now_ms - last_accel_ms;
    last_accel_ms = now_ms;
    row = 26 - lead_zero_count(32'(count_reg & esa_pkg::ROW_MASK));
    if (row < 0) row = 0;
    if (row > 8) row = 8;
    tens = (gap_ms >= 100) ? 10 : int'(gap_ms / 10);
    col = (tens == 0) ? 9 : 10 - tens;
    return esa_pkg::CHANGE_W'(ACCEL_GAIN[row][col] * int'(delta));
  endfunction

  always @(posedge clk) begin : watch
    logic signed [esa_pkg::CHANGE_W-1:0] want;
    logic signed [esa_pkg::CHANGE_W-1:0] got;
    if (rst) begin
      count_reg = '0;
      enc_mode_reg = 1'b0;
      step_count = '0;
      last_accel_ms = '0;
      change_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == esa_pkg::REG_VALUE_COUNT) count_reg = cfg_data;
        else if (cfg_index == esa_pkg::REG_ENCODER_MODE) enc_mode_reg = cfg_data[0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        change_q.push_back(shape_move(s_axis_tuser, s_axis_tdata[esa_pkg::DELTA_W-1:0],
                                      s_axis_tdata[esa_pkg::DELTA_W +: esa_pkg::TIME_W]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (change_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got %0d", $time, got);
          errors++;
        end else begin
          want = change_q.pop_front();
          if (got !== want) begin
            $display("%0t: scaled_change mismatch, expected %0d, got %0d", $time, want, got);
            errors++;
          end
        end
      end
    end
    pending = change_q.size();
  end

endmodule

// File: tb/sv/tb.sv
// testbench top: clock, reset, stimulus and receiver stalls, watchdog and verdict
`timescale 1ns / 1ps
module tb;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;

  logic                         clk;
  logic                         rst;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [esa_pkg::TDATA_W-1:0]  s_axis_tdata;   // delta, time_ms, zero pad
  logic                         s_axis_tuser;   // op
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [esa_pkg::CHANGE_W-1:0] m_axis_tdata;   // scaled_change
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [esa_pkg::IDX_W-1:0]    cfg_index;
  logic [esa_pkg::COUNT_W-1:0]  cfg_data;

  int                           errors;
  int                           pending;
  int                           quiet_cycles;
  bit                           tx_idle;
  bit                           rx_idle;
  bit                           long_hold;
  logic [esa_pkg::TIME_W-1:0]   clock_ms;

  encoder_step_acceleration_unit dut (.*);

  esa_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic op, input logic [esa_pkg::DELTA_W-1:0] delta,
                           input logic [esa_pkg::TIME_W-1:0] t);
    int gap;
    gap = tx_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, t, delta};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [esa_pkg::IDX_W-1:0] idx,
                           input logic [esa_pkg::COUNT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [esa_pkg::COUNT_W-1:0] count, input logic mode);
    write_reg(esa_pkg::REG_VALUE_COUNT, count);
    write_reg(esa_pkg::REG_ENCODER_MODE, esa_pkg::COUNT_W'(mode));
    cfg_valid <= 1'b0;
  endtask

  // drain all results, then let the pipeline settle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin : drain
    int hold;
    m_axis_tready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (long_hold) begin
        hold = LONG_HOLD;
        long_hold = 1'b0;
      end else begin
        hold = rx_idle ? $urandom_range(0, 13) : 0;
      end
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic                        op;
    logic [esa_pkg::DELTA_W-1:0] d;
    logic [esa_pkg::COUNT_W-1:0] count;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = esa_pkg::OP_MOVE;
    cfg_valid = 1'b0;
    cfg_index = esa_pkg::REG_VALUE_COUNT;
    cfg_data = '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    long_hold = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset config: coarse count zero, threshold 16
    send_word(esa_pkg::OP_MOVE, 7'sd63, 32'd0);
    send_word(esa_pkg::OP_MOVE, -7'sd64, 32'hFFFF_FFFF);
    send_word(esa_pkg::OP_MOVE, 7'sd5, 32'd7);
    send_word(esa_pkg::OP_CLEAR, 7'sd5, 32'd7);
    send_word(esa_pkg::OP_MOVE, -7'sd15, 32'd8);
    send_word(esa_pkg::OP_MOVE, -7'sd1, 32'd9);
    settle();

    // widest count, top gain row, column edges and time wrap
    set_config(16'hFFFF, 1'b0);
    send_word(esa_pkg::OP_MOVE, 7'sd63, 32'd0);
    send_word(esa_pkg::OP_MOVE, -7'sd64, 32'd5);
    send_word(esa_pkg::OP_MOVE, 7'sd1, 32'd110);
    send_word(esa_pkg::OP_MOVE, 7'sd1, 32'd165);
    send_word(esa_pkg::OP_CLEAR, 7'sd0, 32'd9999);
    send_word(esa_pkg::OP_MOVE, -7'sd1, 32'hFFFF_FFFF);
    send_word(esa_pkg::OP_MOVE, 7'sd2, 32'd3);
    settle();

    // first count on the gain path, bottom row
    set_config(16'd63, 1'b0);
    send_word(esa_pkg::OP_MOVE, 7'sd1, 32'd10);
    send_word(esa_pkg::OP_MOVE, 7'sd0, 32'd20);
    settle();

    set_config(16'd62, 1'b1);
    send_word(esa_pkg::OP_MOVE, 7'sd7, 32'd0);
    send_word(esa_pkg::OP_MOVE, 7'sd1, 32'd0);
    send_word(esa_pkg::OP_MOVE, -7'sd8, 32'd0);
    settle();

    set_config(16'hFFFF, 1'b1);
    send_word(esa_pkg::OP_MOVE, 7'sd1, 32'd1);
    send_word(esa_pkg::OP_MOVE, 7'sd1, 32'd2);
    send_word(esa_pkg::OP_MOVE, -7'sd2, 32'd3);
    settle();

    set_config(16'd0, 1'b1);
    send_word(esa_pkg::OP_MOVE, 7'sd16, 32'd4);
    send_word(esa_pkg::OP_CLEAR, -7'sd64, 32'd5);

    for (int phase = 0; phase < 24; phase++) begin
      settle();
      case ($urandom_range(0, 9))
        0: count = 16'd0;
        1: count = esa_pkg::COUNT_W'($urandom_range(1, 62));
        2: count = 16'd62;
        3: count = 16'd63;
        4: count = 16'd64;
        5: count = 16'h3FFF;
        6: count = 16'h4000;
        7: count = 16'hFFFF;
        default: count = esa_pkg::COUNT_W'($urandom_range(63, 65535));
      endcase
      set_config(count, $urandom_range(0, 3) == 0);
      tx_idle = (phase % 4) != 1;
      rx_idle = (phase % 4) != 2;
      if (phase == 0) begin
        tx_idle = 1'b0;
        long_hold = 1'b1;
      end
      clock_ms = $urandom();
      repeat (30) begin
        op = ($urandom_range(0, 9) == 0) ? esa_pkg::OP_CLEAR : esa_pkg::OP_MOVE;
        if ($urandom_range(0, 9) < 7) d = esa_pkg::DELTA_W'($urandom_range(0, 6) - 3);
        else d = esa_pkg::DELTA_W'($urandom());
        case ($urandom_range(0, 9))
          0: clock_ms = $urandom();
          1: clock_ms = clock_ms;
          default: clock_ms = clock_ms + $urandom_range(0, 120);
        endcase
        send_word(op, d, clock_ms);
      end
    end

    settle();
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/esa_pkg.sv
design/esa_steps.sv
design/esa_gain.sv
design/encoder_step_acceleration_unit.sv
tb/sv/esa_checker.sv
tb/sv/tb.sv
